[rtl/core/ang_pkg.sv]
// ----------------------------------------------------------------------------
// ang_pkg
// Shared types and constants for the audio noise gate: gain format,
// register map, controller states and the command and config bundles.
// ----------------------------------------------------------------------------
package ang_pkg;

    // gain and coefficient format, unsigned q1.23
    localparam int Q_BITS    = 24;
    localparam int FRAC_BITS = 23;
    localparam logic [Q_BITS-1:0] UNITY_Q = 24'h80_0000;

    // configuration port geometry
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = 3'd4;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GAIN,
        ST_APPLY
    } ang_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic upd_gain;
        logic load_out;
    } ang_cmd_t;

    // configuration register contents
    typedef struct packed {
        logic              enable;
        logic [Q_BITS-1:0] threshold;
        logic [Q_BITS-1:0] floor_gain;
        logic [Q_BITS-1:0] attack;
        logic [Q_BITS-1:0] release_c;
    } ang_cfg_t;

endpackage

[rtl/core/ang_regs.sv]
// ----------------------------------------------------------------------------
// ang_regs
// Configuration register file behind a simple apb-style port.
// ----------------------------------------------------------------------------
module ang_regs
    import ang_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output ang_cfg_t              cfg
);

    ang_cfg_t             cfg_reg;
    ang_cfg_t             cfg_next;
    logic [CFG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_GATE_ENABLE:   cfg_next.enable     = pwdata[0];
                REG_THRESHOLD:     cfg_next.threshold  = pwdata[Q_BITS-1:0];
                REG_FLOOR_GAIN:    cfg_next.floor_gain = pwdata[Q_BITS-1:0];
                REG_ATTACK_COEFF:  cfg_next.attack     = pwdata[Q_BITS-1:0];
                REG_RELEASE_COEFF: cfg_next.release_c  = pwdata[Q_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable     <= 1'b0;
            cfg_reg.threshold  <= '0;
            cfg_reg.floor_gain <= UNITY_Q;
            cfg_reg.attack     <= UNITY_Q;
            cfg_reg.release_c  <= UNITY_Q;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back mux
    always_comb
    begin
        case (idx)
            REG_GATE_ENABLE:   prdata = CFG_DATA_W'(cfg_reg.enable);
            REG_THRESHOLD:     prdata = CFG_DATA_W'(cfg_reg.threshold);
            REG_FLOOR_GAIN:    prdata = CFG_DATA_W'(cfg_reg.floor_gain);
            REG_ATTACK_COEFF:  prdata = CFG_DATA_W'(cfg_reg.attack);
            REG_RELEASE_COEFF: prdata = CFG_DATA_W'(cfg_reg.release_c);
            default:           prdata = '0;
        endcase
    end

endmodule

[rtl/core/ang_ctrl.sv]
// ----------------------------------------------------------------------------
// ang_ctrl
// Frame sequencer: capture, gain update, gain apply, with an output
// register that can hold a word while the next frame is taken in.
// ----------------------------------------------------------------------------
module ang_ctrl
    import ang_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output ang_cmd_t cmd
);

    ang_state_t state_reg;
    ang_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       accept;

    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (out_free)
                    state_next = accept ? ST_GAIN : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and commands
    always_comb
    begin
        s_tready     = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.upd_gain = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_GAIN:
            begin
                cmd.upd_gain = 1'b1;
            end
            ST_APPLY:
            begin
                s_tready     = out_free;
                cmd.load_out = out_free;
                cmd.load_in  = out_free && s_tvalid;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // output word valid flag
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/core/ang_datapath.sv]
// ----------------------------------------------------------------------------
// ang_datapath
// Peak detector, one-pole gain envelope and per-channel gain multipliers.
// ----------------------------------------------------------------------------
module ang_datapath
    import ang_pkg::*;
#(
    parameter int NUM_CHANNELS = 2,
    parameter int SAMPLE_BITS  = 24
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ang_cmd_t                              cmd,
    input  ang_cfg_t                              cfg,
    input  logic [NUM_CHANNELS*SAMPLE_BITS-1:0]   in_data,
    output logic [NUM_CHANNELS*SAMPLE_BITS-1:0]   out_samples,
    output logic [Q_BITS-1:0]                     out_gain,
    output logic                                  out_open
);

    localparam int SW    = NUM_CHANNELS * SAMPLE_BITS;
    localparam int CMP_W = SAMPLE_BITS + FRAC_BITS;
    localparam int GS_W  = Q_BITS + 3;
    localparam int PG_W  = 2 * (Q_BITS + 1);
    localparam int PO_W  = SAMPLE_BITS + Q_BITS + 1;

    logic [SAMPLE_BITS-1:0] det;
    logic [CMP_W-1:0]       det_scaled;
    logic [CMP_W-1:0]       thr_scaled;
    logic                   open_in;

    logic [SW-1:0]          samp_reg;
    logic                   open_reg;
    logic [Q_BITS-1:0]      gain_reg;
    logic [Q_BITS-1:0]      gain_next;

    logic [Q_BITS-1:0]      coef;
    logic [Q_BITS-1:0]      target;
    logic signed [Q_BITS:0] diff;
    logic signed [PG_W-1:0] gprod;
    logic signed [GS_W-1:0] gstep;
    logic signed [GS_W-1:0] gsum;
    logic [Q_BITS-1:0]      gclamp;

    logic [SW-1:0]          lane_next;
    logic [SW-1:0]          lane_reg;
    logic [Q_BITS-1:0]      gain_out_reg;
    logic                   open_out_reg;

    function automatic logic [Q_BITS-1:0] sat_unity(input logic [Q_BITS-1:0] v);
        return (v > UNITY_Q) ? UNITY_Q : v;
    endfunction

    // peak magnitude across channels
    always_comb
    begin
        logic [SAMPLE_BITS-1:0] s_v;
        logic [SAMPLE_BITS-1:0] mag_v;
        det = '0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            s_v   = in_data[ch*SAMPLE_BITS +: SAMPLE_BITS];
            mag_v = s_v[SAMPLE_BITS-1] ? (~s_v + 1'b1) : s_v;
            if (mag_v > det)
                det = mag_v;
        end
    end

    // threshold test, |s| * 2^23 > thr * 2^(bits-1)
    assign det_scaled = CMP_W'(det) << FRAC_BITS;
    assign thr_scaled = CMP_W'(cfg.threshold) << (SAMPLE_BITS - 1);
    assign open_in    = cfg.enable && (det_scaled > thr_scaled);

    // frame capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            samp_reg <= in_data;
            open_reg <= open_in;
        end
    end

    // envelope step toward unity or floor, floored, clamped; unity when the gate is disabled
    always_comb
    begin
        coef   = open_reg ? sat_unity(cfg.attack) : sat_unity(cfg.release_c);
        target = open_reg ? UNITY_Q : sat_unity(cfg.floor_gain);
        diff   = $signed({1'b0, target}) - $signed({1'b0, gain_reg});
        gprod  = $signed({1'b0, coef}) * diff;
        gstep  = GS_W'(gprod >>> FRAC_BITS);
        gsum   = $signed({3'b000, gain_reg}) + gstep;
        if (gsum < 0)
            gclamp = '0;
        else if (gsum > $signed({3'b000, UNITY_Q}))
            gclamp = UNITY_Q;
        else
            gclamp = gsum[Q_BITS-1:0];
        gain_next = cfg.enable ? gclamp : UNITY_Q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= UNITY_Q;
        else if (cmd.upd_gain)
            gain_reg <= gain_next;
    end

    // per-channel gain multiply, floor of q1.23 product
    always_comb
    begin
        logic signed [SAMPLE_BITS-1:0] s_v;
        logic signed [PO_W-1:0]        p_v;
        lane_next = '0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            s_v = $signed(samp_reg[ch*SAMPLE_BITS +: SAMPLE_BITS]);
            p_v = s_v * $signed({1'b0, gain_reg});
            p_v = p_v >>> FRAC_BITS;
            lane_next[ch*SAMPLE_BITS +: SAMPLE_BITS] = p_v[SAMPLE_BITS-1:0];
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            lane_reg     <= lane_next;
            gain_out_reg <= gain_reg;
            open_out_reg <= open_reg;
        end
    end

    assign out_samples = lane_reg;
    assign out_gain    = gain_out_reg;
    assign out_open    = open_out_reg;

endmodule

[rtl/core/audio_noise_gate_top.sv]
// ----------------------------------------------------------------------------
// audio_noise_gate_top
// Noise gate with a one-pole attack/release gain envelope on a stream of
// multichannel frames, configured over an apb-style port.
// ----------------------------------------------------------------------------
// a frame is captured, its gain is updated, then its word goes to the output
//   register once free; frames are taken one at a time, with the gain update
//   multiply and the sample multiply both working from one capture register
// a finished word waits in the output register while the next frame enters
// reset (rst_n, async, active low): gain at unity, registers at defaults,
//   no frame in flight
module audio_noise_gate_top
    import ang_pkg::*;
#(
    parameter int NUM_CHANNELS = 2,
    parameter int SAMPLE_BITS  = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input frames
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sample_ch0, sample_ch1, ... from the lowest bit up, zero padded
    input  logic [((NUM_CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // result frames
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_ch0, out_ch1, ..., gain_now from the lowest bit up, zero padded
    output logic [((NUM_CHANNELS*SAMPLE_BITS+Q_BITS+7)/8)*8-1:0] m_tdata,
    // gate_open
    output logic                  m_tuser,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SW      = NUM_CHANNELS * SAMPLE_BITS;
    localparam int S_DATA_W = ((SW + 7) / 8) * 8;
    localparam int M_DATA_W = ((SW + Q_BITS + 7) / 8) * 8;

    ang_cfg_t          cfg;
    ang_cmd_t          cmd;
    logic [SW-1:0]     out_samples;
    logic [Q_BITS-1:0] out_gain;
    logic              out_open;

    ang_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ang_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ang_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg),
        .in_data     (s_tdata[SW-1:0]),
        .out_samples (out_samples),
        .out_gain    (out_gain),
        .out_open    (out_open)
    );

    // result word packing
    assign m_tdata = M_DATA_W'({out_gain, out_samples});
    assign m_tuser = out_open;

    // padding bits of the input word are not used
    logic unused_pad;
    assign unused_pad = ^{1'b0, s_tdata[S_DATA_W-1:0]};

endmodule
